// ----- sv/utfx_pkg.sv -----
// Shared types, codes and constants of the UTF transcoder.
// Used by the decoder front, the code point queue and the encoder back.
package utfx_pkg;

    localparam logic [1:0] ENC_UTF8  = 2'd0;
    localparam logic [1:0] ENC_UTF16 = 2'd1;
    localparam logic [1:0] ENC_UTF32 = 2'd2;

    localparam int CP_W        = 21;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CP_W-1:0] REPL_CP      = 21'h00FFFD;
    localparam logic [CP_W-1:0] SUPP_BASE    = 21'h010000;
    localparam logic [31:0]     MAX_CP       = 32'h0010FFFF;
    localparam logic [15:0]     SURR_HI_BASE = 16'hD800;
    localparam logic [15:0]     SURR_LO_BASE = 16'hDC00;
    localparam logic [15:0]     SURR_END     = 16'hDFFF;
    localparam logic [15:0]     HI_OUT_BASE  = 16'hD7C0;
    localparam logic [7:0]      LEAD_MIN     = 8'hC2;
    localparam logic [7:0]      LEAD_MAX     = 8'hF4;
    localparam logic [7:0]      CONT_MASK    = 8'h3F;
    localparam logic [15:0]     TEN_BIT_MASK = 16'h03FF;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_TRUNC    = 3'd1,
        ERR_BADCONT  = 3'd2,
        ERR_OVERLONG = 3'd3,
        ERR_SURR     = 3'd4,
        ERR_RANGE    = 3'd5,
        ERR_INVALID  = 3'd6
    } err_code_t;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        err_code_t       err;
    } cp_item_t;

    typedef struct packed {
        cp_item_t item0;
        cp_item_t item1;
        logic     two;
    } q_entry_t;

endpackage

// ----- sv/utfx_front.sv -----
// Decoder front: accepts input code units, tracks open sequences and
// pushes up to two code points per transfer into the queue. Uses utfx_pkg.
module utfx_front import utfx_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [1:0]  in_enc,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_unit,
    input  logic        s_ends_stream,
    input  logic        q_full,
    output logic        push,
    output q_entry_t    push_entry
);

    logic [1:0]      seen_reg, seen_next;
    logic [1:0]      needed_reg, needed_next;
    logic [7:0]      lead_reg, lead_next;
    logic [CP_W-1:0] partial_reg, partial_next;
    logic            held_reg, held_next;
    logic [9:0]      hs_reg, hs_next;

    logic [7:0]      b;
    logic [15:0]     u;
    logic            cont;
    logic            accept;

    logic            f8_emit, f8_lead, f8_open;
    cp_item_t        f8_item;
    logic [1:0]      f8_need;
    logic [CP_W-1:0] f8_part;

    logic            f16_emit, f16_hold, f16_keep;
    cp_item_t        f16_item;

    err_code_t       err8;
    logic [CP_W-1:0] new_part;
    logic            v0, v1;
    cp_item_t        e0, e1;

    assign b       = s_unit[7:0];
    assign u       = s_unit[15:0];
    assign cont    = (b[7:6] == 2'b10);
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        f8_emit = 1'b0;
        f8_lead = 1'b0;
        f8_open = 1'b0;
        f8_item = '{cp: '0, err: ERR_NONE};
        f8_need = 2'd0;
        f8_part = '0;
        priority if (b < 8'h80) begin
            f8_emit = 1'b1;
            f8_item = '{cp: {13'd0, b}, err: ERR_NONE};
        end else if (b < 8'hC0) begin
            f8_emit = 1'b1;
            f8_item = '{cp: REPL_CP, err: ERR_BADCONT};
        end else if (b < LEAD_MIN || b > LEAD_MAX) begin
            f8_emit = 1'b1;
            f8_item = '{cp: REPL_CP, err: ERR_INVALID};
        end else begin
            f8_lead = 1'b1;
            f8_open = !s_ends_stream;
            priority if (b < 8'hE0) begin
                f8_need = 2'd1;
                f8_part = {16'd0, b[4:0]};
            end else if (b < 8'hF0) begin
                f8_need = 2'd2;
                f8_part = {17'd0, b[3:0]};
            end else begin
                f8_need = 2'd3;
                f8_part = {18'd0, b[2:0]};
            end
            if (s_ends_stream) begin
                f8_emit = 1'b1;
                f8_item = '{cp: REPL_CP, err: ERR_TRUNC};
            end
        end
    end

    always_comb begin
        f16_emit = 1'b0;
        f16_hold = 1'b0;
        f16_keep = 1'b0;
        f16_item = '{cp: {5'd0, u}, err: ERR_NONE};
        priority if (u < SURR_HI_BASE || u > SURR_END) begin
            f16_emit = 1'b1;
        end else if (u < SURR_LO_BASE) begin
            f16_hold = 1'b1;
            f16_keep = !s_ends_stream;
            if (s_ends_stream) begin
                f16_emit = 1'b1;
                f16_item = '{cp: REPL_CP, err: ERR_TRUNC};
            end
        end else begin
            f16_emit = 1'b1;
            f16_item = '{cp: REPL_CP, err: ERR_BADCONT};
        end
    end

    always_comb begin
        err8 = ERR_NONE;
        if (seen_reg == 2'd1) begin
            priority if (lead_reg == 8'hE0 && b >= 8'h80 && b < 8'hA0) begin
                err8 = ERR_OVERLONG;
            end else if (lead_reg == 8'hED && b >= 8'hA0 && b < 8'hC0) begin
                err8 = ERR_SURR;
            end else if (lead_reg == 8'hF0 && b >= 8'h80 && b < 8'h90) begin
                err8 = ERR_OVERLONG;
            end else if (lead_reg == 8'hF4 && b >= 8'h90 && b < 8'hC0) begin
                err8 = ERR_RANGE;
            end else if (!cont) begin
                err8 = ERR_TRUNC;
            end
        end else if (!cont) begin
            err8 = ERR_TRUNC;
        end
    end

    assign new_part = {partial_reg[CP_W-7:0], b[5:0] & CONT_MASK[5:0]};

    always_comb begin
        seen_next    = seen_reg;
        needed_next  = needed_reg;
        lead_next    = lead_reg;
        partial_next = partial_reg;
        held_next    = held_reg;
        hs_next      = hs_reg;
        v0           = 1'b0;
        v1           = 1'b0;
        e0           = '{cp: REPL_CP, err: ERR_NONE};
        e1           = '{cp: REPL_CP, err: ERR_NONE};
        unique case (in_enc)
            ENC_UTF8: begin
                if (seen_reg == 2'd0 || err8 != ERR_NONE) begin
                    if (seen_reg == 2'd0) begin
                        v0 = f8_emit;
                        e0 = f8_item;
                    end else begin
                        v0 = 1'b1;
                        e0 = '{cp: REPL_CP, err: err8};
                        v1 = f8_emit;
                        e1 = f8_item;
                    end
                    if (f8_lead) begin
                        lead_next    = b;
                        needed_next  = f8_need;
                        partial_next = f8_part;
                    end
                    seen_next = f8_open ? 2'd1 : 2'd0;
                end else begin
                    partial_next = new_part;
                    if (seen_reg >= needed_reg) begin
                        v0        = 1'b1;
                        e0        = '{cp: new_part, err: ERR_NONE};
                        seen_next = 2'd0;
                    end else if (s_ends_stream) begin
                        v0        = 1'b1;
                        e0        = '{cp: REPL_CP, err: ERR_TRUNC};
                        seen_next = 2'd0;
                    end else begin
                        seen_next = seen_reg + 2'd1;
                    end
                end
            end
            ENC_UTF16: begin
                if (held_reg && u >= SURR_LO_BASE && u <= SURR_END) begin
                    v0        = 1'b1;
                    e0        = '{cp: SUPP_BASE + {1'b0, hs_reg, u[9:0] & TEN_BIT_MASK[9:0]},
                                  err: ERR_NONE};
                    held_next = 1'b0;
                end else begin
                    if (held_reg) begin
                        v0 = 1'b1;
                        e0 = '{cp: REPL_CP, err: ERR_TRUNC};
                        v1 = f16_emit;
                        e1 = f16_item;
                    end else begin
                        v0 = f16_emit;
                        e0 = f16_item;
                    end
                    if (f16_hold) begin
                        hs_next = u[9:0];
                    end
                    held_next = f16_keep;
                end
            end
            default: begin
                v0 = 1'b1;
                priority if (s_unit >= {16'd0, SURR_HI_BASE} && s_unit <= {16'd0, SURR_END}) begin
                    e0 = '{cp: REPL_CP, err: ERR_SURR};
                end else if (s_unit > MAX_CP) begin
                    e0 = '{cp: REPL_CP, err: ERR_RANGE};
                end else begin
                    e0 = '{cp: s_unit[CP_W-1:0], err: ERR_NONE};
                end
            end
        endcase
        if (s_ends_stream) begin
            seen_next = 2'd0;
            held_next = 1'b0;
        end
    end

    assign push       = accept && v0;
    assign push_entry = '{item0: e0, item1: e1, two: v1};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= 2'd0;
            needed_reg  <= 2'd0;
            lead_reg    <= 8'd0;
            partial_reg <= '0;
            held_reg    <= 1'b0;
            hs_reg      <= 10'd0;
        end else if (accept) begin
            seen_reg    <= seen_next;
            needed_reg  <= needed_next;
            lead_reg    <= lead_next;
            partial_reg <= partial_next;
            held_reg    <= held_next;
            hs_reg      <= hs_next;
        end
    end

endmodule

// ----- sv/utfx_queue.sv -----
// Short queue of decoded code point groups between front and back.
// Uses utfx_pkg for the entry type and depth.
module utfx_queue import utfx_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  q_entry_t push_entry,
    output logic     full,
    input  logic     pop,
    output logic     q_valid,
    output q_entry_t head
);

    q_entry_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign head    = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

endmodule

// ----- sv/utfx_back.sv -----
// Encoder back: expands queued code points into output code units,
// one per cycle while the output is not stalled, into the output register. Uses utfx_pkg.
module utfx_back import utfx_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [1:0]      out_enc,
    input  logic            q_valid,
    input  q_entry_t        head,
    output logic            pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [CP_W-1:0] m_code_unit,
    output logic [2:0]      m_error_code,
    output logic            m_last_of_run
);

    function automatic logic [1:0] last_index(logic [1:0] enc, logic [CP_W-1:0] cp);
        logic [1:0] r;
        r = 2'd0;
        unique case (enc)
            ENC_UTF8: begin
                priority if (cp < 21'h80) r = 2'd0;
                else if (cp < 21'h800)    r = 2'd1;
                else if (cp < SUPP_BASE)  r = 2'd2;
                else                      r = 2'd3;
            end
            ENC_UTF16: r = (cp < SUPP_BASE) ? 2'd0 : 2'd1;
            default:   r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [CP_W-1:0] unit_of(logic [1:0] enc, logic [CP_W-1:0] cp,
                                               logic [1:0] idx);
        logic [1:0]      last;
        logic [1:0]      pos;
        logic [5:0]      six;
        logic [15:0]     hi;
        logic [CP_W-1:0] r;
        last = last_index(enc, cp);
        pos  = last - idx;
        hi   = HI_OUT_BASE + {5'd0, cp[20:10]};
        six  = 6'd0;
        r    = cp;
        unique case (enc)
            ENC_UTF8: begin
                if (idx == 2'd0) begin
                    unique case (last)
                        2'd0: r = {14'd0, cp[6:0]};
                        2'd1: r = {13'd0, 3'b110, cp[10:6]};
                        2'd2: r = {13'd0, 4'b1110, cp[15:12]};
                        default: r = {13'd0, 5'b11110, cp[20:18]};
                    endcase
                end else begin
                    unique case (pos)
                        2'd0: six = cp[5:0];
                        2'd1: six = cp[11:6];
                        default: six = cp[17:12];
                    endcase
                    r = {13'd0, 2'b10, six};
                end
            end
            ENC_UTF16: begin
                if (last == 2'd0) begin
                    r = cp;
                end else if (idx == 2'd0) begin
                    r = {5'd0, hi};
                end else begin
                    r = {5'd0, SURR_LO_BASE[15:10], cp[9:0]};
                end
            end
            default: r = cp;
        endcase
        return r;
    endfunction

    logic            sel_reg, sel_next;
    logic [1:0]      idx_reg, idx_next;
    logic            m_valid_reg, m_valid_next;
    logic [CP_W-1:0] m_code_unit_reg;
    logic [2:0]      m_error_code_reg;
    logic            m_last_reg;

    cp_item_t        cur;
    logic [1:0]      cur_last;
    logic            load, last_unit, last_cp;

    assign cur       = sel_reg ? head.item1 : head.item0;
    assign cur_last  = last_index(out_enc, cur.cp);
    assign load      = q_valid && (!m_valid_reg || m_ready);
    assign last_unit = (idx_reg == cur_last);
    assign last_cp   = sel_reg || !head.two;
    assign pop       = load && last_unit && last_cp;

    always_comb begin
        sel_next     = sel_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (load) begin
            m_valid_next = 1'b1;
            if (last_unit) begin
                idx_next = 2'd0;
                sel_next = !last_cp;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg     <= 1'b0;
            idx_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            sel_reg     <= sel_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_code_unit_reg  <= unit_of(out_enc, cur.cp, idx_reg);
            m_error_code_reg <= cur.err;
            m_last_reg       <= last_unit && last_cp;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_code_unit   = m_code_unit_reg;
    assign m_error_code  = m_error_code_reg;
    assign m_last_of_run = m_last_reg;

endmodule

// ----- sv/utf_transcoder_with_error_replace_core.sv -----
// Top level of the UTF transcoder: register port, decoder front, queue, encoder back.
// Depends on utfx_pkg, utfx_front, utfx_queue and utfx_back.
//
//  channel  | signals                                       | direction
//  ---------+-----------------------------------------------+----------
//  input    | s_valid s_ready s_unit s_ends_stream          | in
//  result   | m_valid m_ready m_code_unit m_error_code      | out
//           | m_last_of_run                                 |
//  config   | psel penable pwrite paddr pwdata prdata pready| in/out
//
// The front takes one code unit per cycle while the four-entry queue has room.
// The back sends one code unit per cycle unless m_ready holds it; a code point becomes
// 1 to 4 units there, so an input unit yields 0 to 6 output units from the single encoder.
// Results pass through a queue slot and then the output register after their transfer.
// Reset is synchronous and clears sequence state, queue and output valid.
module utf_transcoder_with_error_replace_core import utfx_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [31:0]     s_unit,
    input  logic            s_ends_stream,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [CP_W-1:0] m_code_unit,
    output logic [2:0]      m_error_code,
    output logic            m_last_of_run
);

    logic [1:0] in_enc_reg, out_enc_reg;
    logic       wr_en;
    logic       push, q_full, q_valid, pop;
    q_entry_t   push_entry, head;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign prdata = {30'd0, paddr[2] ? out_enc_reg : in_enc_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_enc_reg  <= ENC_UTF8;
            out_enc_reg <= ENC_UTF8;
        end else if (wr_en) begin
            if (paddr[2]) begin
                out_enc_reg <= pwdata[1:0];
            end else begin
                in_enc_reg <= pwdata[1:0];
            end
        end
    end

    utfx_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_enc        (in_enc_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_unit        (s_unit),
        .s_ends_stream (s_ends_stream),
        .q_full        (q_full),
        .push          (push),
        .push_entry    (push_entry)
    );

    utfx_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .head       (head)
    );

    utfx_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .out_enc       (out_enc_reg),
        .q_valid       (q_valid),
        .head          (head),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_code_unit   (m_code_unit),
        .m_error_code  (m_error_code),
        .m_last_of_run (m_last_of_run)
    );

endmodule

// ----- sv/utfx_checker.sv -----
// Port-level checks of the UTF transcoder, bound to the top level.
// Depends on utfx_pkg and utf_transcoder_with_error_replace_core.
module utfx_checker import utfx_pkg::*; (
    input logic            aclk,
    input logic            aresetn,
    input logic            m_valid,
    input logic            m_ready,
    input logic [CP_W-1:0] m_code_unit,
    input logic [2:0]      m_error_code
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_code_unit) && $stable(m_error_code))
        else $error("result transfer dropped or changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_err_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_error_code <= ERR_INVALID)
        else $error("error class out of range");

    a_err_repl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error_code != ERR_NONE |->
            (m_code_unit == REPL_CP || m_code_unit == 21'hEF ||
             m_code_unit == 21'hBF || m_code_unit == 21'hBD))
        else $error("error tagged on a unit that is not a replacement unit");

endmodule

bind utf_transcoder_with_error_replace_core utfx_checker u_chk (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_code_unit  (m_code_unit),
    .m_error_code (m_error_code)
);
